// File: hdl/mac_client_packet_counter_defines.svh
// ---------------------------------------------------------------------------
// mac_client_packet_counter_defines
// Assertion macros shared by the client packet counter RTL.
// ---------------------------------------------------------------------------
`ifndef MAC_CLIENT_PACKET_COUNTER_DEFINES_SVH
`define MAC_CLIENT_PACKET_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define MCPC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset
`define MCPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/mcpc_pkg.sv
// ---------------------------------------------------------------------------
// mcpc_pkg
// Types and constants of the client packet counter.
// ---------------------------------------------------------------------------
package mcpc_pkg;

   localparam int MAC_W           = 48;
   localparam int BYTE_W          = 8;
   localparam int COUNT_W         = 32;
   localparam int CLIENT_INDEX_W  = 6;
   localparam int POS_W           = 5;
   localparam int DEF_MAX_CLIENTS = 64;

   // Byte positions inside a frame
   localparam logic [POS_W-1:0] SRC_FIRST      = 5'd16;
   localparam logic [POS_W-1:0] DST_FIRST      = 5'd22;
   localparam logic [POS_W-1:0] LAST_ADDR_BYTE = 5'd27;
   localparam logic [POS_W-1:0] POS_MAX        = 5'd31;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic              last_byte;
   } req_word_type;

   typedef struct packed {
      logic                      matched;
      logic [CLIENT_INDEX_W-1:0] client_index;
      logic [COUNT_W-1:0]        packet_count;
      logic                      is_new;
      logic                      table_full;
   } rsp_word_type;

endpackage

// File: hdl/mac_client_packet_counter.sv
// ---------------------------------------------------------------------------
// mac_client_packet_counter: one frame byte per cycle while req_ready is high.
// A last byte holds req_ready low while the frame is checked and the table is scanned, one entry
// per cycle, and while the previous result word is still waiting on rsp_ready.
// Result word is registered: S_CHECK, then S_SEARCH if matched and S_UPDATE on a hit, then S_EMIT.
// Synchronous reset clears control and client_total; the table needs no sweep.
// ---------------------------------------------------------------------------
`include "mac_client_packet_counter_defines.svh"

module mac_client_packet_counter
   import mcpc_pkg::*;
#(
   parameter int MAX_CLIENTS = DEF_MAX_CLIENTS
) (
   input  logic                  clock,
   input  logic                  reset,
   // frame byte input
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_data,
   // result output
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_data,
   // access point address register
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [MAC_W-1:0]      csr_data
);

   localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
   localparam int CNT_W = $clog2(MAX_CLIENTS + 1);
   localparam logic [CNT_W-1:0] TOTAL_MAX = CNT_W'(MAX_CLIENTS);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_CHECK  = 5'b00010,
      S_SEARCH = 5'b00100,
      S_UPDATE = 5'b01000,
      S_EMIT   = 5'b10000
   } state_type;

   // Client index as reported: low bits of the table index
   function automatic logic [CLIENT_INDEX_W-1:0] to_client_index(input logic [IDX_W-1:0] idx);
      logic [IDX_W+CLIENT_INDEX_W-1:0] ext;
      ext = {{CLIENT_INDEX_W{1'b0}}, idx};
      return ext[CLIENT_INDEX_W-1:0];
   endfunction

   // Client table memories
   logic [MAC_W-1:0]   addr_mem [MAX_CLIENTS];
   logic [COUNT_W-1:0] cnt_mem  [MAX_CLIENTS];

   state_type          state_ff, state_in;
   logic [MAC_W-1:0]   ap_ff, ap_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [MAC_W-1:0]   src_ff, src_in;
   logic [MAC_W-1:0]   dst_ff, dst_in;
   logic               long_ff, long_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [MAC_W-1:0]   addr_rd_ff;
   logic [COUNT_W-1:0] cnt_rd_ff;
   logic [IDX_W-1:0]   upd_idx_ff, upd_idx_in;
   logic [COUNT_W-1:0] upd_cnt_ff, upd_cnt_in;
   rsp_word_type       res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_data_ff, rsp_data_in;

   logic               req_fire;
   logic               issue;
   logic               hit;
   logic [IDX_W-1:0]   rd_addr;
   logic               addr_we;
   logic               cnt_we;
   logic [IDX_W-1:0]   wr_idx;
   logic [COUNT_W-1:0] cnt_wr_data;
   logic [COUNT_W-1:0] cnt_sat;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Scan control: issue reads while entries remain, compare in the following cycle
   assign issue   = (state_ff == S_SEARCH) && (scan_ff < total_ff);
   assign rd_addr = scan_ff[IDX_W-1:0];
   assign hit     = rd_vld_ff && (addr_rd_ff == dst_ff);
   assign wr_idx  = (state_ff == S_UPDATE) ? upd_idx_ff : total_ff[IDX_W-1:0];
   assign cnt_sat = (upd_cnt_ff == {COUNT_W{1'b1}}) ? upd_cnt_ff : upd_cnt_ff + 1'b1;

   // Byte capture
   always_comb begin
      pos_in  = pos_ff;
      src_in  = src_ff;
      dst_in  = dst_ff;
      long_in = long_ff;
      if (req_fire) begin
         if (pos_ff >= SRC_FIRST && pos_ff < DST_FIRST) begin
            src_in = {src_ff[MAC_W-BYTE_W-1:0], req_data.frame_byte};
         end else if (pos_ff >= DST_FIRST && pos_ff <= LAST_ADDR_BYTE) begin
            dst_in = {dst_ff[MAC_W-BYTE_W-1:0], req_data.frame_byte};
         end
         if (req_data.last_byte) begin
            pos_in  = '0;
            long_in = (pos_ff >= LAST_ADDR_BYTE);
         end else if (pos_ff < POS_MAX) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   // Frame-end sequencer
   always_comb begin
      state_in    = state_ff;
      total_in    = total_ff;
      scan_in     = scan_ff;
      rd_vld_in   = 1'b0;
      rd_idx_in   = rd_addr;
      upd_idx_in  = upd_idx_ff;
      upd_cnt_in  = upd_cnt_ff;
      res_in      = res_ff;
      addr_we     = 1'b0;
      cnt_we      = 1'b0;
      cnt_wr_data = cnt_sat;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_data.last_byte) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            res_in  = '0;
            scan_in = '0;
            if (long_ff && (src_ff == ap_ff)) begin
               res_in.matched = 1'b1;
               state_in       = S_SEARCH;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_SEARCH: begin
            if (hit) begin
               upd_idx_in = rd_idx_ff;
               upd_cnt_in = cnt_rd_ff;
               state_in   = S_UPDATE;
            end else if (scan_ff == total_ff) begin
               // unknown client: insert, or flag a full table
               if (total_ff == TOTAL_MAX) begin
                  res_in.table_full = 1'b1;
               end else begin
                  addr_we             = 1'b1;
                  cnt_we              = 1'b1;
                  cnt_wr_data         = {{(COUNT_W-1){1'b0}}, 1'b1};
                  res_in.client_index = to_client_index(total_ff[IDX_W-1:0]);
                  res_in.packet_count = {{(COUNT_W-1){1'b0}}, 1'b1};
                  res_in.is_new       = 1'b1;
                  total_in            = total_ff + 1'b1;
               end
               state_in = S_EMIT;
            end else begin
               rd_vld_in = issue;
               scan_in   = scan_ff + 1'b1;
            end
         end
         S_UPDATE: begin
            cnt_we              = 1'b1;
            res_in.client_index = to_client_index(upd_idx_ff);
            res_in.packet_count = cnt_sat;
            state_in            = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Address register
   always_comb begin
      ap_in = ap_ff;
      if (csr_valid && csr_ready) begin
         ap_in = csr_data;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ap_ff        <= '0;
         pos_ff       <= '0;
         src_ff       <= '0;
         dst_ff       <= '0;
         long_ff      <= 1'b0;
         total_ff     <= '0;
         scan_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ap_ff        <= ap_in;
         pos_ff       <= pos_in;
         src_ff       <= src_in;
         dst_ff       <= dst_in;
         long_ff      <= long_in;
         total_ff     <= total_in;
         scan_ff      <= scan_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      upd_idx_ff  <= upd_idx_in;
      upd_cnt_ff  <= upd_cnt_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Table memories: one write, one registered read per cycle. A write lands before the
   // next frame's scan, with S_EMIT, S_IDLE and S_CHECK between, so no forwarding.
   always_ff @(posedge clock) begin
      if (addr_we) begin
         addr_mem[wr_idx] <= dst_ff;
      end
      addr_rd_ff <= addr_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[wr_idx] <= cnt_wr_data;
      end
      cnt_rd_ff <= cnt_mem[rd_addr];
   end

   // Checks
   `MCPC_ASSERT_NEXT(a_busy_after_last, clock, reset, req_valid && req_ready && req_data.last_byte, !req_ready, "block still ready after a last byte")
   `MCPC_ASSERT_IMPLY(a_total_bound, clock, reset, 1'b1, total_ff <= TOTAL_MAX, "client total beyond table size")
   `MCPC_ASSERT_IMPLY(a_unmatched_zero, clock, reset, rsp_valid && !rsp_data.matched, rsp_data.packet_count == '0 && !rsp_data.is_new && !rsp_data.table_full, "unmatched word carries data")
   `MCPC_ASSERT_IMPLY(a_counted_nonzero, clock, reset, rsp_valid && rsp_data.matched && !rsp_data.table_full, rsp_data.packet_count != '0, "counted client has zero count")

endmodule

// File: verif/mac_client_packet_counter_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// mac_client_packet_counter_tb
// Streams sniffed frames byte by byte into the client packet counter, keeps
// its own copy of the client table and checks every result word in order.
// Runs through several access point addresses and idling patterns, revisits
// known clients and stalls the result side long enough to back up the input.
// ---------------------------------------------------------------------------
module mac_client_packet_counter_tb;
   import mcpc_pkg::*;

   localparam int LONG_HOLD   = 400;
   localparam int SETTLE      = DEF_MAX_CLIENTS + 8;
   localparam int STALL_LIMIT = 4000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_word_type        req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_word_type        rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [MAC_W-1:0]    csr_data = '0;

   // words waiting to be sent, and result words still owed by the block
   req_word_type        frame_bytes_q[$];
   rsp_word_type        client_reports_due[$];

   // shadow of the block's state
   bit [MAC_W-1:0]      ap_cfg = '0;
   bit [MAC_W-1:0]      tbl_mac[DEF_MAX_CLIENTS];
   bit [COUNT_W-1:0]    tbl_count[DEF_MAX_CLIENTS];
   int                  n_clients = 0;
   logic [POS_W-1:0]    byte_pos = '0;
   bit [MAC_W-1:0]      src_cap = '0;
   bit [MAC_W-1:0]      dst_cap = '0;

   // stimulus shaping
   int                  send_gap_pct = 0;
   int                  stall_pct = 0;
   int                  hold_trigger = 0;
   int                  hold_seen;
   int                  hold_left;
   bit [MAC_W-1:0]      dst_pool[$];
   bit                  dst_seen[bit [MAC_W-1:0]];

   // bookkeeping
   int                  mismatches = 0;
   int                  frames_done = 0;
   int                  matched_total = 0;
   int                  new_total = 0;
   int                  full_total = 0;
   int                  words_sent = 0;
   int                  idle_cycles;

   mac_client_packet_counter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // Client table update for one accepted byte; a last byte owes one word
   function automatic void track_frame_byte(req_word_type w);
      rsp_word_type r;
      int           slot;
      bit           hit;
      r    = '0;
      slot = 0;
      hit  = 1'b0;
      words_sent++;
      if (byte_pos >= SRC_FIRST && byte_pos < DST_FIRST)
         src_cap = {src_cap[MAC_W-9:0], w.frame_byte};
      else if (byte_pos >= DST_FIRST && byte_pos <= LAST_ADDR_BYTE)
         dst_cap = {dst_cap[MAC_W-9:0], w.frame_byte};
      if (w.last_byte) begin
         frames_done++;
         // length is position + 1, so 28 bytes means position 27
         if (byte_pos >= LAST_ADDR_BYTE && src_cap == ap_cfg) begin
            r.matched = 1'b1;
            matched_total++;
            for (int i = 0; i < n_clients && !hit; i++) begin
               if (tbl_mac[i] == dst_cap) begin
                  slot = i;
                  hit  = 1'b1;
               end
            end
            if (!hit && n_clients >= DEF_MAX_CLIENTS) begin
               r.table_full = 1'b1;
               full_total++;
            end else begin
               if (!hit) begin
                  slot            = n_clients;
                  tbl_mac[slot]   = dst_cap;
                  tbl_count[slot] = '0;
                  n_clients++;
                  r.is_new = 1'b1;
                  new_total++;
               end
               if (tbl_count[slot] != '1)
                  tbl_count[slot]++;
               r.client_index = slot[CLIENT_INDEX_W-1:0];
               r.packet_count = tbl_count[slot];
            end
         end
         client_reports_due.push_back(r);
         byte_pos = '0;
      end else if (byte_pos < POS_MAX) begin
         byte_pos++;
      end
   endfunction

   task automatic note_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   function automatic bit [MAC_W-1:0] rand_mac();
      bit [63:0] v;
      v = {$urandom(), $urandom()};
      return v[MAC_W-1:0];
   endfunction

   // Byte stream driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            track_frame_byte(req_data);
         if (!req_valid || req_ready) begin
            if (frame_bytes_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               req_valid <= 1'b1;
               req_data  <= frame_bytes_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_seen <= 0;
      end else if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Result checker
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (client_reports_due.size() == 0) begin
            note_mismatch($sformatf("result word with nothing owed: %h", rsp_data));
         end else begin
            want = client_reports_due.pop_front();
            if (rsp_data.matched !== want.matched)
               note_mismatch($sformatf("matched %b, want %b", rsp_data.matched,
                                       want.matched));
            if (rsp_data.client_index !== want.client_index)
               note_mismatch($sformatf("client_index %0d, want %0d",
                                       rsp_data.client_index, want.client_index));
            if (rsp_data.packet_count !== want.packet_count)
               note_mismatch($sformatf("packet_count %0d, want %0d",
                                       rsp_data.packet_count, want.packet_count));
            if (rsp_data.is_new !== want.is_new)
               note_mismatch($sformatf("is_new %b, want %b", rsp_data.is_new,
                                       want.is_new));
            if (rsp_data.table_full !== want.table_full)
               note_mismatch($sformatf("table_full %b, want %b", rsp_data.table_full,
                                       want.table_full));
         end
      end
   end

   // Watchdog: cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // One frame of len bytes; address bytes go out most significant first
   task automatic queue_frame(input int len, input bit [MAC_W-1:0] src,
                              input bit [MAC_W-1:0] dst);
      req_word_type w;
      for (int k = 0; k < len; k++) begin
         w.frame_byte = $urandom_range(255);
         if (k >= SRC_FIRST && k < DST_FIRST)
            w.frame_byte = src[MAC_W-1-8*(k-SRC_FIRST) -: 8];
         else if (k >= DST_FIRST && k <= LAST_ADDR_BYTE)
            w.frame_byte = dst[MAC_W-1-8*(k-DST_FIRST) -: 8];
         w.last_byte = (k == len - 1);
         frame_bytes_q.push_back(w);
      end
   endtask

   // Mostly well-formed frames from the access point, some short or foreign
   task automatic queue_random_frame();
      int             len;
      int             pick;
      bit [MAC_W-1:0] src;
      bit [MAC_W-1:0] dst;
      pick = $urandom_range(99);
      if (pick < 15)
         len = $urandom_range(1, 27);
      else if (pick < 75)
         len = 28;
      else
         len = $urandom_range(29, 45);
      pick = $urandom_range(99);
      if (pick < 85)
         src = ap_cfg;
      else if (pick < 95)
         src = ap_cfg ^ (48'h1 << $urandom_range(MAC_W - 1));
      else
         src = rand_mac();
      if (dst_pool.size() != 0 && $urandom_range(99) < 45)
         dst = dst_pool[$urandom_range(dst_pool.size() - 1)];
      else
         dst = rand_mac();
      if (src == ap_cfg && len >= 28 && !dst_seen.exists(dst)) begin
         dst_seen[dst] = 1'b1;
         dst_pool.push_back(dst);
      end
      queue_frame(len, src, dst);
   endtask

   task automatic write_ap(input bit [MAC_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      ap_cfg = value;
      csr_valid <= 1'b0;
   endtask

   // Wait until every word is sent and answered, then let a table scan finish;
   // sampled between edges so that the driver's updates have settled
   task automatic drain();
      while (frame_bytes_q.size() != 0 || req_valid || client_reports_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // no idling; address all zeros, directed frames first
      write_ap('0);
      queue_frame(1, '0, '0);
      queue_frame(27, '0, '0);
      queue_frame(28, '0, '0);
      queue_frame(40, '0, '0);
      queue_frame(28, 48'h1, '0);
      for (int f = 0; f < 5; f++) queue_random_frame();
      drain();

      // sender idle most of the time; address all ones
      send_gap_pct = 69;
      write_ap('1);
      queue_frame(28, '1, '1);
      queue_frame(33, '1, '1);
      for (int f = 0; f < 5; f++) queue_random_frame();
      drain();

      // receiver stalling most of the time
      send_gap_pct = 0;
      stall_pct    = 69;
      write_ap(rand_mac());
      for (int f = 0; f < 5; f++) queue_random_frame();
      drain();

      // both sides idle now and then
      send_gap_pct = 23;
      stall_pct    = 23;
      write_ap(rand_mac());
      for (int f = 0; f < 5; f++) queue_random_frame();
      drain();

      // long hold-off on results while the sender keeps pushing
      send_gap_pct = 0;
      stall_pct    = 0;
      write_ap(rand_mac());
      hold_trigger++;
      for (int f = 0; f < 6; f++) queue_random_frame();
      drain();

      $display("%0d bytes in %0d frames, %0d from the access point", words_sent,
               frames_done, matched_total);
      $display("%0d clients added, %0d frames refused by a full table", new_total,
               full_total);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
